>>> design/pfc_pkg.sv
package pfc_pkg;

    localparam int VALUE_FIELD_W = 16;
    localparam int POS_W = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_TEST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic advance;
        logic set_prime;
        logic prime_val;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic lt2;
        logic sq_gt_v;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } t_sts;

endpackage

>>> design/pfc_in_if.sv
interface pfc_in_if
    import pfc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [VALUE_FIELD_W-1:0] value;
    logic                     last_in_list;

    modport source (output valid, value, last_in_list, input ready);
    modport sink (input valid, value, last_in_list, output ready);
endinterface

>>> design/pfc_out_if.sv
interface pfc_out_if
    import pfc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [VALUE_FIELD_W-1:0] value_out;
    logic                     is_prime;
    logic [POS_W-1:0]         position;
    logic                     list_full_drop;
    logic                     end_of_list;

    modport source (
        output valid, value_out, is_prime, position, list_full_drop, end_of_list,
        input ready
    );
    modport sink (
        input valid, value_out, is_prime, position, list_full_drop, end_of_list,
        output ready
    );
endinterface

>>> design/pfc_ctrl.sv
module pfc_ctrl
    import pfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.lt2 || i_sts.sq_gt_v) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.rem_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_CHECK: begin
                if (i_sts.lt2) begin
                    o_cmd.set_prime = 1'b1;
                    o_cmd.prime_val = 1'b0;
                end else if (i_sts.sq_gt_v) begin
                    o_cmd.set_prime = 1'b1;
                    o_cmd.prime_val = 1'b1;
                end else begin
                    o_cmd.start_div = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_TEST: begin
                if (i_sts.rem_zero) begin
                    o_cmd.set_prime = 1'b1;
                    o_cmd.prime_val = 1'b0;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CHECK))
        else $error("Accepted transaction did not start the test.");

    a_div_to_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_TEST))
        else $error("Remainder sweep did not end in the test state.");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("Result written while the output register was occupied.");

endmodule

>>> design/pfc_datapath.sv
module pfc_datapath
    import pfc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,
    parameter int LIST_DEPTH  = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [VALUE_FIELD_W-1:0] i_value,
    input  logic                     i_last,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    pfc_out_if.source                o_out
);

    localparam int DW = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;
    localparam int BW = $clog2(DW);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [DW-1:0]   r_v;
    logic            r_last;
    logic [DW-1:0]   r_d;
    logic [2*DW-1:0] r_sq;
    logic [DW:0]     r_rem;
    logic [BW-1:0]   r_bit;
    logic            r_prime;
    logic [CW-1:0]   r_count;

    logic                     r_out_valid;
    logic [VALUE_FIELD_W-1:0] r_value_out;
    logic                     r_is_prime;
    logic [POS_W-1:0]         r_position;
    logic                     r_drop;
    logic                     r_eol;

    logic [DW:0] w_shift;
    logic [DW:0] w_dext;
    logic        w_room;
    logic [31:0] w_cnt32;

    assign w_shift = {r_rem[DW-1:0], r_v[r_bit]};
    assign w_dext  = {1'b0, r_d};
    assign w_room  = (r_count < CW'(LIST_DEPTH));
    assign w_cnt32 = 32'(r_count);

    assign o_sts.lt2      = (r_v < DW'(2));
    assign o_sts.sq_gt_v  = (r_sq > (2*DW)'(r_v));
    assign o_sts.div_last = (r_bit == '0);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_value[DW-1:0];
            r_last <= i_last;
            r_d    <= DW'(2);
            r_sq   <= (2*DW)'(4);
        end
        if (i_cmd.start_div) begin
            r_rem <= '0;
            r_bit <= BW'(DW - 1);
        end
        if (i_cmd.div_step) begin
            if (w_shift >= w_dext) begin
                r_rem <= w_shift - w_dext;
            end else begin
                r_rem <= w_shift;
            end
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.advance) begin
            r_d  <= r_d + 1'b1;
            r_sq <= r_sq + {{(DW-1){1'b0}}, r_d, 1'b1};
        end
        if (i_cmd.set_prime) begin
            r_prime <= i_cmd.prime_val;
        end
        if (i_cmd.finish) begin
            r_value_out <= VALUE_FIELD_W'(r_v);
            r_is_prime  <= r_prime;
            r_eol       <= r_last;
            r_position  <= (r_prime && w_room) ? w_cnt32[POS_W-1:0] : '0;
            r_drop      <= r_prime && !w_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_count <= '0;
                end else if (r_prime && w_room) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value_out      = r_value_out;
    assign o_out.is_prime       = r_is_prime;
    assign o_out.position       = r_position;
    assign o_out.list_full_drop = r_drop;
    assign o_out.end_of_list    = r_eol;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("Kept count exceeds the list depth.");

    a_drop_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_drop) |-> r_is_prime)
        else $error("Drop flagged on a value that is not prime.");

    a_eol_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_last) |=> (r_count == '0))
        else $error("Kept count not cleared after the end of the list.");

endmodule

>>> design/prime_filter_compactor.sv
// Tests each incoming value for primality by trial division with divisors from 2 while the
// square of the divisor does not exceed the value, and numbers each prime with its place in a
// compacted list of LIST_DEPTH entries; the count clears after the transaction marked last,
// and primes that find the list full are flagged as dropped. Every divisor costs one bit-serial
// remainder sweep over min(VALUE_WIDTH, 16) bits of the value, framed by the check and test
// states, and a finished result waits until the output register is free. One item is tested
// at a time, and a new transaction is accepted while the previous result still waits in the
// output register.
module prime_filter_compactor
    import pfc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,
    parameter int LIST_DEPTH  = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfc_in_if.sink    i_in,
    pfc_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_in.ready = w_ready;

    pfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pfc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .LIST_DEPTH  (LIST_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_in.value),
        .i_last  (i_in.last_in_list),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

endmodule

>>> tb/prime_result_monitor.sv
module prime_result_monitor
    import pfc_pkg::*;
#(
    parameter int LIST_DEPTH = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pfc_in_if    i_in,
    pfc_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value_out;
        logic                     is_prime;
        logic [POS_W-1:0]         position;
        logic                     list_full_drop;
        logic                     end_of_list;
    } t_prime_verdict;

    t_prime_verdict expected_verdicts[$];
    int unsigned    primes_kept = 0;
    int             mismatches = 0;

    function automatic logic trial_divide_prime(input logic [VALUE_FIELD_W-1:0] v);
        int unsigned d;
        if (v < 2) return 1'b0;
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic compare_field(input string field, input logic [VALUE_FIELD_W-1:0] expected_v,
                                 input logic [VALUE_FIELD_W-1:0] actual_v);
        if (actual_v !== expected_v) begin
            $error("%s: expected %0d, got %0d", field, expected_v, actual_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_prime_verdict want;
        if (!i_rst_n) begin
            expected_verdicts.delete();
            primes_kept = 0;
        end else begin
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (expected_verdicts.size() == 0) begin
                    $error("value_out: expected no transaction, got %0d", i_out.value_out);
                    mismatches++;
                end else begin
                    want = expected_verdicts.pop_front();
                    compare_field("value_out", want.value_out, i_out.value_out);
                    compare_field("is_prime", want.is_prime, i_out.is_prime);
                    compare_field("position", want.position, i_out.position);
                    compare_field("list_full_drop", want.list_full_drop, i_out.list_full_drop);
                    compare_field("end_of_list", want.end_of_list, i_out.end_of_list);
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                want.value_out      = i_in.value;
                want.is_prime       = trial_divide_prime(i_in.value);
                want.position       = '0;
                want.list_full_drop = 1'b0;
                want.end_of_list    = i_in.last_in_list;
                if (want.is_prime) begin
                    if (primes_kept < LIST_DEPTH) begin
                        want.position = primes_kept[POS_W-1:0];
                        primes_kept++;
                    end else begin
                        want.list_full_drop = 1'b1;
                    end
                end
                if (i_in.last_in_list) primes_kept = 0;
                expected_verdicts.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_verdicts.size();
    end

endmodule

>>> tb/prime_filter_compactor_tb.sv
module prime_filter_compactor_tb
    import pfc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH       = 128;
    localparam int RESET_CYCLES     = 7;
    localparam int MAX_IDLE         = 16;
    localparam int LONG_HOLD_CYCLES = 2000;
    localparam int DRAIN_CYCLES     = 5000;
    localparam int FILL_PRIMES      = 20;
    localparam int RANDOM_CHUNKS    = 3;
    localparam int CHUNK_ITEMS      = 20;

    localparam int unsigned SMALL_PRIMES [25] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73, 79,
        83, 89, 97
    };

    localparam logic [VALUE_FIELD_W:0] DIRECTED [20] = '{
        {1'b0, 16'd0},     {1'b0, 16'd1},     {1'b0, 16'd2},     {1'b0, 16'd3},
        {1'b0, 16'd4},     {1'b0, 16'd25},    {1'b0, 16'd49},    {1'b0, 16'd121},
        {1'b0, 16'd65025}, {1'b0, 16'd65521}, {1'b0, 16'd65535}, {1'b0, 16'd32768},
        {1'b0, 16'd65534}, {1'b1, 16'd7},     {1'b0, 16'd11},    {1'b1, 16'd9},
        {1'b1, 16'd13},    {1'b1, 16'd0},     {1'b0, 16'd2},     {1'b1, 16'd65521}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic sender_idles;
    logic receiver_idles;
    logic hold_request = 1'b0;
    int   fail_count;
    int   pending;

    pfc_in_if  in_ch ();
    pfc_out_if out_ch ();

    prime_filter_compactor #(
        .VALUE_WIDTH(VALUE_FIELD_W),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    prime_result_monitor #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_item(input logic [VALUE_FIELD_W-1:0] v, input logic closes_list);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.value        <= v;
        in_ch.last_in_list <= closes_list;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_request) begin
                stall        = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            @(negedge clk);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (out_ch.valid !== 1'b1) @(posedge clk);
        end
    end

    initial begin
        logic [VALUE_FIELD_W-1:0] v;
        logic [1:0]               mode;
        int unsigned              pick;
        int                       primes_sent;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.value        = '0;
        in_ch.last_in_list = 1'b0;
        sender_idles       = 1'b1;
        receiver_idles     = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i][VALUE_FIELD_W-1:0], DIRECTED[i][VALUE_FIELD_W]);
        end
        wait_for_results();

        // One list of small primes with some even values mixed in, while the receiver holds off at
        // its start so that the input side backs up.
        sender_idles = 1'b0;
        hold_request = 1'b1;
        primes_sent  = 0;
        while (primes_sent < FILL_PRIMES) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(VALUE_FIELD_W'(2 * $urandom_range(2, 500)), 1'b0);
            end else begin
                send_item(VALUE_FIELD_W'(SMALL_PRIMES[$urandom_range(0, 24)]),
                          primes_sent == FILL_PRIMES - 1);
                primes_sent++;
            end
        end

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            mode           = (chunk == 0) ? 2'b00 : 2'($urandom_range(1, 3));
            sender_idles   = mode[0];
            receiver_idles = mode[1];
            repeat (CHUNK_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    v = VALUE_FIELD_W'($urandom_range(0, 255));
                end else if (pick < 7) begin
                    v = VALUE_FIELD_W'($urandom_range(0, 4095));
                end else begin
                    v = VALUE_FIELD_W'($urandom());
                end
                send_item(v, $urandom_range(0, 9) == 0);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
